@@ sv/ovl_pkg.sv @@
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and constants for the ordered value list: the list depth,
// derived widths, command and status codes and the controller interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ovl_pkg;

  // List depth and the widths that follow from it.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths of the stream beats.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned ECNT_W   = 5;
  localparam int unsigned IN_RAW_W  = CMD_W + VAL_W;
  localparam int unsigned IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W = STS_W + POS_W + VAL_W + ECNT_W;
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND      = 3'd0,
    CMD_SEARCH      = 3'd1,
    CMD_REMOVE_LAST = 3'd2,
    CMD_REMOVE_VAL  = 3'd3,
    CMD_CLEAR       = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_EXECUTE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the input beat
    logic compare;  // register the match vector
    logic execute;  // update the list and load the result register
  } ctrl_cmd_t;

endpackage : ovl_pkg

`default_nettype wire

@@ sv/ovl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ovl_ctrl
// Controller: sequences capture, compare and execute for each command and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ovl_ctrl
  import ovl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_d = ST_EXECUTE;
      end
      ST_EXECUTE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs to the handshake and the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_COMPARE: begin
        cmd_o.compare = 1'b1;
      end
      ST_EXECUTE: begin
        cmd_o.execute = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : ovl_ctrl

`default_nettype wire

@@ sv/ovl_dp.sv @@
// ----------------------------------------------------------------------------
// ovl_dp
// Datapath: the row of list entries with parallel compare, the entry count,
// the gap-closing shift and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ovl_dp
  import ovl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  input  wire logic [CMD_W-1:0]   in_command_i,
  input  wire logic [VAL_W-1:0]   in_value_i,
  output logic      [STS_W-1:0]   status_o,
  output logic      [POS_W-1:0]   position_o,
  output logic      [VAL_W-1:0]   removed_value_o,
  output logic      [ECNT_W-1:0]  entry_count_o
);

  logic [VAL_W-1:0]  entries_q [DEPTH];
  logic [VAL_W-1:0]  entries_d [DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CMD_W-1:0]  command_q;
  logic [VAL_W-1:0]  value_q;
  logic [DEPTH-1:0]  match_q, match_d;

  logic              found;
  logic [IDX_W-1:0]  first_idx;
  logic              empty;
  logic              full;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  last_idx;

  status_e           status_d;
  logic [POS_W-1:0]  position_d;
  logic [VAL_W-1:0]  removed_d;

  // Capture the command beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      command_q <= in_command_i;
      value_q   <= in_value_i;
    end
  end

  // Each cell compares its entry with the value; cells past the tail never match.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (entries_q[i] == value_q) && (CNT_W'(i) < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) match_q <= match_d;
  end

  // Priority encoder: lowest matching cell.
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        found     = 1'b1;
        first_idx = IDX_W'(i);
      end
    end
  end

  assign empty    = (count_q == '0);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign tail_idx = count_q[IDX_W-1:0];
  assign last_idx = IDX_W'(count_q - CNT_W'(1));

  // Command execution: next list contents, count and result fields.
  always_comb begin
    entries_d  = entries_q;
    count_d    = count_q;
    status_d   = STS_OK;
    position_d = '0;
    removed_d  = '0;
    case (command_q)
      CMD_APPEND: begin
        if (full) begin
          status_d = STS_FULL;
        end else begin
          entries_d[tail_idx] = value_q;
          count_d             = count_q + CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else if (!found) begin
          status_d = STS_NOT_FOUND;
        end else begin
          position_d = POS_W'(first_idx);
        end
      end
      CMD_REMOVE_LAST: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          removed_d = entries_q[last_idx];
          count_d   = count_q - CNT_W'(1);
        end
      end
      CMD_REMOVE_VAL: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else if (!found) begin
          status_d = STS_NOT_FOUND;
        end else begin
          // Cells at and above the match take their upper neighbour.
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= first_idx) entries_d[i] = entries_q[i+1];
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // Unused codes leave the list as it is.
        count_d = count_q;
      end
    endcase
  end

  // List storage holds no reset; only cells below the count are ever read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) entries_q <= entries_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_o        <= status_d;
      position_o      <= position_d;
      removed_value_o <= removed_d;
      entry_count_o   <= ECNT_W'(count_d);
    end
  end

endmodule : ovl_dp

`default_nettype wire

@@ sv/ordered_value_list.sv @@
// Capture, compare and execute run in turn for each command; a result beat is
// valid once execute loads the result register, and no new command is taken
// before execute, which waits while a full result register is not drained.
// The next command is taken while a finished result still waits at the output.
// Reset clears the entry count and the result valid flag; list cells are not
// reset and are never read before being written.
// ----------------------------------------------------------------------------
// ordered_value_list
// Bounded list of signed 32-bit values in insertion order with append,
// search, remove last, remove by value and clear commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_value_list
  import ovl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_W-1:0]   s_axis_tdata,   // command[2:0], value[34:3]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_W-1:0]  m_axis_tdata    // status[1:0], position[5:2],
                                                 // removed_value[37:6],
                                                 // entry_count[42:38]
);

  ctrl_cmd_t         cmd;
  logic [STS_W-1:0]  status;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  removed_value;
  logic [ECNT_W-1:0] entry_count;

  ovl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ovl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_command_i    (s_axis_tdata[CMD_W-1:0]),
    .in_value_i      (s_axis_tdata[CMD_W+VAL_W-1:CMD_W]),
    .status_o        (status),
    .position_o      (position),
    .removed_value_o (removed_value),
    .entry_count_o   (entry_count)
  );

  // Pack the result beat, padded with zeros to whole bytes.
  assign m_axis_tdata = {{(OUT_W - OUT_RAW_W){1'b0}},
                         entry_count, removed_value, position, status};

endmodule : ordered_value_list

`default_nettype wire

@@ sv/ovl_checker.sv @@
// ----------------------------------------------------------------------------
// ovl_checker
// Port-level checks on the ordered value list: result beat stability and
// consistency of status, count and removed value.
// ----------------------------------------------------------------------------
`default_nettype none

module ovl_checker
  import ovl_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  logic [STS_W-1:0]  status;
  logic [VAL_W-1:0]  removed_value;
  logic [ECNT_W-1:0] entry_count;

  assign status        = m_axis_tdata[STS_W-1:0];
  assign removed_value = m_axis_tdata[STS_W+POS_W+VAL_W-1:STS_W+POS_W];
  assign entry_count   = m_axis_tdata[OUT_RAW_W-1:STS_W+POS_W+VAL_W];

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The reported count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> entry_count <= ECNT_W'(DEPTH))
    else $error("entry count beyond list depth");

  // A full status is only given with a full list.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == STS_FULL |-> entry_count == ECNT_W'(DEPTH))
    else $error("full status with room left");

  // An empty status comes with an empty list and nothing removed.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == STS_EMPTY |-> entry_count == '0 && removed_value == '0)
    else $error("empty status with entries present");

endmodule : ovl_checker

bind ordered_value_list ovl_checker u_ovl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
